// File: hdl/arap_se_pkg.sv
// shared types, widths and helpers for the arap stress and energy pipeline
package arap_se_pkg;

    localparam int F_W    = 24;
    localparam int MU_W   = 24;
    localparam int E_W    = 32;
    localparam int FRAC_W = 16;
    localparam int MAG_W  = F_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ROOT_W = MAG_W;
    localparam int DIV_W  = MAG_W + FRAC_W;
    localparam int Q_W    = FRAC_W + 1;
    localparam int SHIFT_W = 5;
    localparam int D_W    = F_W + 2;
    localparam int PROD_W = MU_W + 1 + D_W;
    localparam int NRM_W  = 50;
    localparam int LO_W   = 24;
    localparam int HI_W   = NRM_W - LO_W;

    localparam logic [MU_W-1:0] MU_RESET = MU_W'(65536);
    localparam logic [Q_W-1:0]  ONE_Q    = Q_W'(65536);

    typedef logic signed [F_W-1:0] fix_t;

    typedef struct packed {
        fix_t f_row0_col0;
        fix_t f_row0_col1;
        fix_t f_row1_col0;
        fix_t f_row1_col1;
    } arap_in_t;

    typedef struct packed {
        fix_t            p_row0_col0;
        fix_t            p_row0_col1;
        fix_t            p_row1_col0;
        fix_t            p_row1_col1;
        logic [E_W-1:0]  strain_energy;
        logic            clipped;
    } arap_out_t;

    typedef struct packed {
        arap_in_t f;
        logic     a_neg;
        logic     b_neg;
        logic     zero;
    } side_t;

    localparam int SIDE_W      = $bits(side_t);
    localparam int SQRT_SIDE_W = SIDE_W + 2 * MAG_W;

    function automatic logic signed [D_W-1:0] to_d(input logic [F_W-1:0] v);
        return {{(D_W-F_W){v[F_W-1]}}, v};
    endfunction

endpackage

// File: hdl/arap_stress_energy_2x2_core.sv
// throughput: one request per cycle; a stalled result freezes the whole pipeline
// depth is set by the 25-stage square root and the 18-stage cosine/sine divider
// reset (synchronous, active low) empties the pipeline and sets shear modulus to 1.0
module arap_stress_energy_2x2_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  arap_se_pkg::arap_in_t        s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output arap_se_pkg::arap_out_t       m_data,
    input  logic                         cfg_wr_en,
    input  logic [arap_se_pkg::MU_W-1:0] cfg_wr_data
);
    import arap_se_pkg::*;

    logic [MU_W-1:0] mu_reg;
    logic            en;

    logic              fr_valid;
    side_t             fr_side;
    logic [MAG_W-1:0]  fr_ua, fr_ub;
    logic [SQ_W-1:0]   fr_x;

    logic                   sq_valid;
    logic [ROOT_W-1:0]      sq_root;
    logic [SQRT_SIDE_W-1:0] sq_side;
    side_t                  sq_side_s;
    logic [MAG_W-1:0]       sq_ua, sq_ub;

    logic           dv_valid;
    logic [Q_W-1:0] dv_qc, dv_qs;
    side_t          dv_side;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg <= MU_RESET;
        end else if (cfg_wr_en) begin
            mu_reg <= cfg_wr_data;
        end
    end

    arap_se_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_ua    (fr_ua),
        .out_ub    (fr_ub),
        .out_x     (fr_x)
    );

    arap_se_isqrt #(
        .SIDE_W (SQRT_SIDE_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_x      (fr_x),
        .in_side   ({fr_side, fr_ua, fr_ub}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign {sq_side_s, sq_ua, sq_ub} = sq_side;

    arap_se_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_ua     (sq_ua),
        .in_ub     (sq_ub),
        .in_h      (sq_root),
        .in_side   (sq_side_s),
        .out_valid (dv_valid),
        .out_qc    (dv_qc),
        .out_qs    (dv_qs),
        .out_side  (dv_side)
    );

    arap_se_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .mu        (mu_reg),
        .in_valid  (dv_valid),
        .in_qc     (dv_qc),
        .in_qs     (dv_qs),
        .in_side   (dv_side),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule

// File: hdl/arap_se_front.sv
// front end: rotation terms, magnitudes, normalization and sum of squares
module arap_se_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  arap_se_pkg::arap_in_t      in_data,
    output logic                       out_valid,
    output arap_se_pkg::side_t         out_side,
    output logic [arap_se_pkg::MAG_W-1:0] out_ua,
    output logic [arap_se_pkg::MAG_W-1:0] out_ub,
    output logic [arap_se_pkg::SQ_W-1:0]  out_x
);
    import arap_se_pkg::*;

    logic [4:0] valid_reg;

    logic signed [MAG_W-1:0] a_reg, b_reg;
    arap_in_t f1_reg;
    side_t    s2_reg, s3_reg, s4_reg, s5_reg;
    logic [MAG_W-1:0] ua2_reg, ub2_reg, ua3_reg, ub3_reg, ua4_reg, ub4_reg, ua5_reg, ub5_reg;
    logic [SQ_W-1:0]  sqa4_reg, sqb4_reg, x5_reg;

    logic signed [MAG_W-1:0] a_next, b_next;
    logic [MAG_W-1:0] ua_next, ub_next, m_or, ua_n_next, ub_n_next;
    logic [SHIFT_W-1:0] k_next;

    always_comb begin
        a_next = MAG_W'(in_data.f_row1_col0) - MAG_W'(in_data.f_row0_col1);
        b_next = MAG_W'(in_data.f_row0_col0) + MAG_W'(in_data.f_row1_col1);
    end

    always_comb begin
        ua_next = a_reg[MAG_W-1] ? MAG_W'(-a_reg) : MAG_W'(a_reg);
        ub_next = b_reg[MAG_W-1] ? MAG_W'(-b_reg) : MAG_W'(b_reg);
    end

    // normalize so the larger magnitude reaches bit 23, or stays at bit 24 if it is already there
    always_comb begin
        m_or   = ua2_reg | ub2_reg;
        k_next = '0;
        if (!(m_or[MAG_W-1] | m_or[MAG_W-2])) begin
            for (int i = 0; i < MAG_W - 2; i++) begin
                if (m_or[i]) k_next = SHIFT_W'(MAG_W - 2 - i);
            end
        end
        ua_n_next = ua2_reg << k_next;
        ub_n_next = ub2_reg << k_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            f1_reg   <= in_data;
            s2_reg.f     <= f1_reg;
            s2_reg.a_neg <= a_reg[MAG_W-1];
            s2_reg.b_neg <= b_reg[MAG_W-1];
            s2_reg.zero  <= (a_reg == '0) && (b_reg == '0);
            ua2_reg  <= ua_next;
            ub2_reg  <= ub_next;
            s3_reg   <= s2_reg;
            ua3_reg  <= ua_n_next;
            ub3_reg  <= ub_n_next;
            s4_reg   <= s3_reg;
            ua4_reg  <= ua3_reg;
            ub4_reg  <= ub3_reg;
            sqa4_reg <= ua3_reg * ua3_reg;
            sqb4_reg <= ub3_reg * ub3_reg;
            s5_reg   <= s4_reg;
            ua5_reg  <= ua4_reg;
            ub5_reg  <= ub4_reg;
            x5_reg   <= sqa4_reg + sqb4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_side  = s5_reg;
    assign out_ua    = ua5_reg;
    assign out_ub    = ub5_reg;
    assign out_x     = x5_reg;

endmodule

// File: hdl/arap_se_isqrt.sv
// pipelined integer square root, one root bit per stage
module arap_se_isqrt #(
    parameter int SIDE_W = arap_se_pkg::SQRT_SIDE_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [arap_se_pkg::SQ_W-1:0]   in_x,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [arap_se_pkg::ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]              out_side
);
    import arap_se_pkg::*;

    logic [ROOT_W-1:0] valid_reg;
    logic [SQ_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar t = 0; t < ROOT_W; t++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - t;
        logic [SQ_W-1:0]   rem_in, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [SIDE_W-1:0] side_in;
        logic              v_in;

        if (t == 0) begin : g_first
            assign rem_in  = in_x;
            assign root_in = '0;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[t-1];
            assign root_in = root_reg[t-1];
            assign side_in = side_reg[t-1];
            assign v_in    = valid_reg[t-1];
        end

        always_comb begin
            trial     = ({{(SQ_W-ROOT_W){1'b0}}, root_in} << (BIT + 1))
                      | (SQ_W'(1) << (2 * BIT));
            rem_next  = rem_in;
            root_next = root_in;
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << BIT);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[t] <= 1'b0;
            end else if (en) begin
                valid_reg[t] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[t]  <= rem_next;
                root_reg[t] <= root_next;
                side_reg[t] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// File: hdl/arap_se_div.sv
// pipelined restoring divider for cosine and sine, one quotient bit per stage
module arap_se_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [arap_se_pkg::MAG_W-1:0] in_ua,
    input  logic [arap_se_pkg::MAG_W-1:0] in_ub,
    input  logic [arap_se_pkg::ROOT_W-1:0] in_h,
    input  arap_se_pkg::side_t            in_side,
    output logic                          out_valid,
    output logic [arap_se_pkg::Q_W-1:0]   out_qc,
    output logic [arap_se_pkg::Q_W-1:0]   out_qs,
    output arap_se_pkg::side_t            out_side
);
    import arap_se_pkg::*;

    logic              pre_valid_reg;
    logic [DIV_W-1:0]  nc_reg, ns_reg;
    logic [ROOT_W-1:0] hp_reg;
    side_t             sp_reg;

    logic [Q_W-1:0]    valid_reg;
    logic [DIV_W-1:0]  remc_reg [Q_W];
    logic [DIV_W-1:0]  rems_reg [Q_W];
    logic [Q_W-1:0]    qc_reg   [Q_W];
    logic [Q_W-1:0]    qs_reg   [Q_W];
    logic [ROOT_W-1:0] h_reg    [Q_W];
    side_t             side_reg [Q_W];

    logic [DIV_W-1:0] nc_next, ns_next;

    // rounded numerators: magnitude scaled by 2^16 plus half the divisor
    always_comb begin
        nc_next = {in_ub, FRAC_W'(0)} + DIV_W'(in_h >> 1);
        ns_next = {in_ua, FRAC_W'(0)} + DIV_W'(in_h >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nc_reg <= nc_next;
            ns_reg <= ns_next;
            hp_reg <= in_h;
            sp_reg <= in_side;
        end
    end

    for (genvar t = 0; t < Q_W; t++) begin : g_stage
        localparam int BIT = Q_W - 1 - t;
        logic [DIV_W-1:0]  remc_in, rems_in, dsh, remc_next, rems_next;
        logic [Q_W-1:0]    qc_in, qs_in, qc_next, qs_next;
        logic [ROOT_W-1:0] h_in;
        side_t             side_in;
        logic              v_in;

        if (t == 0) begin : g_first
            assign remc_in = nc_reg;
            assign rems_in = ns_reg;
            assign qc_in   = '0;
            assign qs_in   = '0;
            assign h_in    = hp_reg;
            assign side_in = sp_reg;
            assign v_in    = pre_valid_reg;
        end else begin : g_rest
            assign remc_in = remc_reg[t-1];
            assign rems_in = rems_reg[t-1];
            assign qc_in   = qc_reg[t-1];
            assign qs_in   = qs_reg[t-1];
            assign h_in    = h_reg[t-1];
            assign side_in = side_reg[t-1];
            assign v_in    = valid_reg[t-1];
        end

        always_comb begin
            dsh       = DIV_W'(h_in) << BIT;
            remc_next = remc_in;
            rems_next = rems_in;
            qc_next   = qc_in;
            qs_next   = qs_in;
            if (remc_in >= dsh) begin
                remc_next = remc_in - dsh;
                qc_next   = qc_in | (Q_W'(1) << BIT);
            end
            if (rems_in >= dsh) begin
                rems_next = rems_in - dsh;
                qs_next   = qs_in | (Q_W'(1) << BIT);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[t] <= 1'b0;
            end else if (en) begin
                valid_reg[t] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                remc_reg[t] <= remc_next;
                rems_reg[t] <= rems_next;
                qc_reg[t]   <= qc_next;
                qs_reg[t]   <= qs_next;
                h_reg[t]    <= h_in;
                side_reg[t] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_qc    = qc_reg[Q_W-1];
    assign out_qs    = qs_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// File: hdl/arap_se_back.sv
// back end: difference to rotation, stress rounding and saturation, energy
module arap_se_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [arap_se_pkg::MU_W-1:0] mu,
    input  logic                         in_valid,
    input  logic [arap_se_pkg::Q_W-1:0]  in_qc,
    input  logic [arap_se_pkg::Q_W-1:0]  in_qs,
    input  arap_se_pkg::side_t           in_side,
    output logic                         out_valid,
    output arap_se_pkg::arap_out_t       out_data
);
    import arap_se_pkg::*;

    localparam int QS_W = PROD_W - FRAC_W;
    localparam logic signed [QS_W-1:0] P_MAX = QS_W'((1 << (F_W - 1)) - 1);
    localparam logic signed [QS_W-1:0] P_MIN = -QS_W'(1 << (F_W - 1));
    localparam logic [E_W+9:0] E_MAX = {10'd0, {E_W{1'b1}}};

    logic [4:0] valid_reg;

    logic signed [D_W-1:0]    d_reg    [4];
    logic signed [PROD_W-1:0] prod_reg [4];
    logic [NRM_W-1:0]         sqr_reg  [4];
    logic [F_W-1:0]           p3_reg   [4];
    logic [F_W-1:0]           p4_reg   [4];
    logic [F_W-1:0]           p5_reg   [4];
    logic [NRM_W-1:0]         n_reg;
    logic                     clip3_reg, clip4_reg, clip5_reg;
    logic [2*MU_W-1:0]        lo_reg;
    logic [MU_W+HI_W-1:0]     hi_reg;
    logic [E_W-1:0]           e5_reg;

    logic signed [D_W-1:0]    cq_next, sq_next;
    logic signed [D_W-1:0]    d_next   [4];
    logic signed [PROD_W-1:0] prod_next[4];
    logic [NRM_W-1:0]         sqr_next [4];
    logic [F_W-1:0]           p_next   [4];
    logic                     clip_next;
    logic [NRM_W-1:0]         n_next;
    logic signed [PROD_W-1:0] rnd;
    logic signed [QS_W-1:0]   q;
    logic [D_W-1:0]           mag;
    logic [2*MU_W:0]          low;
    logic [MU_W+HI_W:0]       esum;
    logic [E_W+9:0]           e_wide;
    logic [E_W-1:0]           e_next;
    logic                     eclip_next;

    // rotation entries, identity when both rotation terms vanish
    always_comb begin
        if (in_side.zero) begin
            cq_next = D_W'(ONE_Q);
            sq_next = '0;
        end else begin
            cq_next = in_side.b_neg ? -D_W'(in_qc) : D_W'(in_qc);
            sq_next = in_side.a_neg ? -D_W'(in_qs) : D_W'(in_qs);
        end
        d_next[0] = to_d(in_side.f.f_row0_col0) - cq_next;
        d_next[1] = to_d(in_side.f.f_row0_col1) + sq_next;
        d_next[2] = to_d(in_side.f.f_row1_col0) - sq_next;
        d_next[3] = to_d(in_side.f.f_row1_col1) - cq_next;
    end

    always_comb begin
        mag = '0;
        for (int i = 0; i < 4; i++) begin
            prod_next[i] = $signed({1'b0, mu}) * d_reg[i];
            mag = d_reg[i][D_W-1] ? D_W'(-d_reg[i]) : D_W'(d_reg[i]);
            sqr_next[i] = mag[MAG_W-1:0] * mag[MAG_W-1:0];
        end
    end

    // round to nearest, ties up, then clamp
    always_comb begin
        clip_next = 1'b0;
        rnd = '0;
        q = '0;
        for (int i = 0; i < 4; i++) begin
            rnd = prod_reg[i] + PROD_W'(32768);
            q   = QS_W'(rnd >>> FRAC_W);
            if (q > P_MAX) begin
                p_next[i] = P_MAX[F_W-1:0];
                clip_next = 1'b1;
            end else if (q < P_MIN) begin
                p_next[i] = P_MIN[F_W-1:0];
                clip_next = 1'b1;
            end else begin
                p_next[i] = q[F_W-1:0];
            end
        end
        n_next = sqr_reg[0] + sqr_reg[1] + sqr_reg[2] + sqr_reg[3];
    end

    always_comb begin
        low    = {1'b0, lo_reg} + (( 2*MU_W+1)'(1) << E_W);
        esum   = {1'b0, hi_reg} + (MU_W+HI_W+1)'(low >> LO_W);
        e_wide = (E_W+10)'(esum >> 9);
        eclip_next = e_wide > E_MAX;
        e_next = eclip_next ? {E_W{1'b1}} : e_wide[E_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg     <= d_next;
            prod_reg  <= prod_next;
            sqr_reg   <= sqr_next;
            p3_reg    <= p_next;
            clip3_reg <= clip_next;
            n_reg     <= n_next;
            p4_reg    <= p3_reg;
            clip4_reg <= clip3_reg;
            lo_reg    <= mu * n_reg[LO_W-1:0];
            hi_reg    <= mu * n_reg[NRM_W-1:LO_W];
            p5_reg    <= p4_reg;
            clip5_reg <= clip4_reg | eclip_next;
            e5_reg    <= e_next;
        end
    end

    always_comb begin
        out_data.p_row0_col0   = p5_reg[0];
        out_data.p_row0_col1   = p5_reg[1];
        out_data.p_row1_col0   = p5_reg[2];
        out_data.p_row1_col1   = p5_reg[3];
        out_data.strain_energy = e5_reg;
        out_data.clipped       = clip5_reg;
    end

    assign out_valid = valid_reg[4];

endmodule
